// ===== sv/pgc_pkg.sv =====
// Shared types, codes and constants of the pointer gesture classifier.
package pgc_pkg;

  // Input operation codes.
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_PRESS   = 3'd1;
  localparam logic [2:0] OP_MOVE    = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_WHEEL   = 3'd4;
  localparam logic [2:0] OP_OTHER   = 3'd5;

  // Result kind codes.
  localparam logic [3:0] KIND_CLICK      = 4'd6;
  localparam logic [3:0] KIND_DOUBLE     = 4'd7;
  localparam logic [3:0] KIND_DRAG_START = 4'd8;
  localparam logic [3:0] KIND_DRAG       = 4'd9;
  localparam logic [3:0] KIND_DRAG_STOP  = 4'd10;

  // Configuration register indexes (byte address divided by four).
  localparam logic [1:0] REG_CLICK_MAX_SHIFT  = 2'd0;
  localparam logic [1:0] REG_CLICK_MAX_DELAY  = 2'd1;
  localparam logic [1:0] REG_DOUBLE_MAX_DELAY = 2'd2;

  localparam int unsigned ADDR_W = 4;

  // Reset values of the configuration registers.
  localparam logic [11:0] RST_CLICK_MAX_SHIFT    = 12'd80;
  localparam logic [23:0] RST_CLICK_MAX_SHIFT_SQ = 24'd6400;
  localparam logic [23:0] RST_CLICK_MAX_DELAY    = 24'd250000;
  localparam logic [23:0] RST_DOUBLE_MAX_DELAY   = 24'd200000;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [11:0] shift;
    logic [23:0] shift_sq;
    logic [23:0] click_delay;
    logic [23:0] dbl_delay;
  } pgc_cfg_t;

  // One decoded event waiting in the queue.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [1:0]         button;
    logic [7:0]         mods;
    logic [47:0]        stamp;
    logic               take_time;
  } pgc_item_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [1:0]         out_button;
    logic [7:0]         out_mods;
    logic signed [15:0] press_x;
    logic signed [15:0] press_y;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic signed [16:0] shift_x;
    logic signed [16:0] shift_y;
    logic               press_valid;
  } pgc_result_t;

endpackage

// ===== sv/pgc_regs.sv =====
// Configuration registers behind the APB-style port.
module pgc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pgc_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output pgc_pkg::pgc_cfg_t              cfg_o
);

  pgc_pkg::pgc_cfg_t cfg_q, cfg_d;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        pgc_pkg::REG_CLICK_MAX_SHIFT: begin
          cfg_d.shift    = pwdata[11:0];
          // The squared limit is kept so the distance test needs no multiply by it.
          cfg_d.shift_sq = 24'(pwdata[11:0]) * 24'(pwdata[11:0]);
        end
        pgc_pkg::REG_CLICK_MAX_DELAY:  cfg_d.click_delay = pwdata[23:0];
        pgc_pkg::REG_DOUBLE_MAX_DELAY: cfg_d.dbl_delay   = pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shift       <= pgc_pkg::RST_CLICK_MAX_SHIFT;
      cfg_q.shift_sq    <= pgc_pkg::RST_CLICK_MAX_SHIFT_SQ;
      cfg_q.click_delay <= pgc_pkg::RST_CLICK_MAX_DELAY;
      cfg_q.dbl_delay   <= pgc_pkg::RST_DOUBLE_MAX_DELAY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      pgc_pkg::REG_CLICK_MAX_SHIFT:  prdata = {20'd0, cfg_q.shift};
      pgc_pkg::REG_CLICK_MAX_DELAY:  prdata = {8'd0, cfg_q.click_delay};
      pgc_pkg::REG_DOUBLE_MAX_DELAY: prdata = {8'd0, cfg_q.dbl_delay};
      default:                       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/pgc_front.sv =====
// Front end: accepts event words, decodes them and drops the ones that do nothing.
module pgc_front (
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  logic [95:0]            s_data_i,
  input  logic [2:0]             s_user_i,
  input  logic                   full_i,
  output logic                   push_o,
  output pgc_pkg::pgc_item_t     item_o
);

  logic op_known;
  logic op_timed;

  assign s_ready_o = !full_i;

  always_comb begin
    op_timed = (s_user_i == pgc_pkg::OP_PRESS) || (s_user_i == pgc_pkg::OP_MOVE) ||
               (s_user_i == pgc_pkg::OP_RELEASE) || (s_user_i == pgc_pkg::OP_WHEEL);
    // The pass-through kind is known but leaves the time alone.
    op_known = op_timed || (s_user_i == pgc_pkg::OP_OTHER);

    item_o.op        = s_user_i;
    item_o.x         = s_data_i[15:0];
    item_o.y         = s_data_i[31:16];
    item_o.button    = s_data_i[33:32];
    item_o.mods      = s_data_i[41:34];
    item_o.stamp     = s_data_i[89:42];
    item_o.take_time = op_timed && (s_data_i[89:42] != 48'd0);
  end

  // Unknown codes and the empty operation are accepted and discarded here.
  assign push_o = s_valid_i && !full_i && op_known;

endmodule

// ===== sv/pgc_fifo.sv =====
// Short queue of decoded events between the front end and the gesture engine.
module pgc_fifo #(
  parameter int unsigned Depth = pgc_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pgc_pkg::pgc_item_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output pgc_pkg::pgc_item_t rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  pgc_pkg::pgc_item_t mem_q [Depth];
  logic [PtrW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    priority if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count beyond its depth");

endmodule

// ===== sv/pgc_back.sv =====
// Gesture engine: the state machine, position and time tracking, and the output register.
module pgc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pgc_pkg::pgc_cfg_t    cfg_i,
  input  logic                 empty_i,
  input  pgc_pkg::pgc_item_t   item_i,
  output logic                 pop_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output pgc_pkg::pgc_result_t result_o
);

  localparam logic [2:0] ST_RELEASED    = 3'd0;
  localparam logic [2:0] ST_PRESS       = 3'd1;
  localparam logic [2:0] ST_CLICK       = 3'd2;
  localparam logic [2:0] ST_CLICK_PRESS = 3'd3;
  localparam logic [2:0] ST_DOUBLE      = 3'd4;
  localparam logic [2:0] ST_DRAGGING    = 3'd5;

  logic [2:0]         state_q, state_d, st;
  logic signed [15:0] press_x_q, press_x_d, press_y_q, press_y_d;
  logic signed [15:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic signed [15:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [47:0]        now_q, press_time_q, press_time_d, now_d;

  logic [23:0]        limit;
  logic [48:0]        tdiff;
  logic               in_time;
  logic signed [16:0] dx, dy;
  logic [16:0]        mag_x, mag_y;
  logic [23:0]        sq_x, sq_y;
  logic [24:0]        travel_sq;
  logic               far;

  pgc_pkg::pgc_result_t res, res_q;
  logic                 res_valid, m_valid_q, m_valid_d;

  // Codes six and seven would behave as released.
  assign st = (state_q > ST_DRAGGING) ? ST_RELEASED : state_q;

  assign pop_o = !empty_i && (!m_valid_q || m_ready_i);

  // Press-to-event delay against the limit that the operation calls for;
  // time running backwards counts as no delay.
  always_comb begin
    now_d   = item_i.take_time ? item_i.stamp : now_q;
    limit   = (item_i.op == pgc_pkg::OP_PRESS) ? cfg_i.dbl_delay : cfg_i.click_delay;
    tdiff   = {1'b0, now_d} - {1'b0, press_time_q};
    in_time = tdiff[48] || (tdiff[47:0] <= {24'd0, limit});
  end

  // Squared travel from the press point. A component of 4096 or more already
  // exceeds the largest squared limit, so only 12-bit squares are needed.
  always_comb begin
    dx        = {item_i.x[15], item_i.x} - {press_x_q[15], press_x_q};
    dy        = {item_i.y[15], item_i.y} - {press_y_q[15], press_y_q};
    mag_x     = dx[16] ? (~dx + 17'd1) : dx;
    mag_y     = dy[16] ? (~dy + 17'd1) : dy;
    sq_x      = 24'(mag_x[11:0]) * 24'(mag_x[11:0]);
    sq_y      = 24'(mag_y[11:0]) * 24'(mag_y[11:0]);
    travel_sq = {1'b0, sq_x} + {1'b0, sq_y};
    far       = (|mag_x[16:12]) || (|mag_y[16:12]) ||
                (travel_sq > {1'b0, cfg_i.shift_sq});
  end

  always_comb begin
    state_d      = st;
    press_x_d    = press_x_q;
    press_y_d    = press_y_q;
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    press_time_d = press_time_q;

    res_valid       = 1'b1;
    res.kind        = {1'b0, item_i.op};
    res.out_x       = item_i.x;
    res.out_y       = item_i.y;
    res.out_button  = item_i.button;
    res.out_mods    = item_i.mods;
    res.press_x     = '0;
    res.press_y     = '0;
    res.prev_x      = '0;
    res.prev_y      = '0;
    res.shift_x     = '0;
    res.shift_y     = '0;
    res.press_valid = 1'b0;

    unique case (item_i.op)
      pgc_pkg::OP_PRESS: begin
        cur_x_d      = item_i.x;
        cur_y_d      = item_i.y;
        press_time_d = now_d;
        if (st == ST_RELEASED) begin
          press_x_d = item_i.x;
          press_y_d = item_i.y;
        end
        unique case (st)
          ST_PRESS, ST_DRAGGING: res_valid = 1'b0;
          ST_RELEASED, ST_DOUBLE: state_d = ST_PRESS;
          ST_CLICK: state_d = in_time ? ST_CLICK_PRESS : ST_PRESS;
          default: ;
        endcase
      end
      pgc_pkg::OP_MOVE: begin
        last_x_d = cur_x_q;
        last_y_d = cur_y_q;
        cur_x_d  = item_i.x;
        cur_y_d  = item_i.y;
        unique case (st)
          ST_PRESS, ST_CLICK_PRESS: begin
            if (far) begin
              state_d         = ST_DRAGGING;
              res.kind        = pgc_pkg::KIND_DRAG_START;
              res.press_x     = press_x_q;
              res.press_y     = press_y_q;
              res.press_valid = 1'b1;
            end
          end
          ST_CLICK: begin
            if (far) begin
              state_d = ST_RELEASED;
            end
          end
          ST_DOUBLE: state_d = ST_RELEASED;
          ST_DRAGGING: begin
            res.kind        = pgc_pkg::KIND_DRAG;
            res.press_x     = press_x_q;
            res.press_y     = press_y_q;
            res.prev_x      = cur_x_q;
            res.prev_y      = cur_y_q;
            res.shift_x     = dx;
            res.shift_y     = dy;
            res.press_valid = 1'b1;
          end
          default: ;
        endcase
      end
      pgc_pkg::OP_RELEASE: begin
        cur_x_d = item_i.x;
        cur_y_d = item_i.y;
        unique case (st)
          ST_RELEASED, ST_CLICK: res_valid = 1'b0;
          ST_DOUBLE: state_d = ST_RELEASED;
          ST_DRAGGING: begin
            state_d         = ST_RELEASED;
            res.kind        = pgc_pkg::KIND_DRAG_STOP;
            res.press_x     = press_x_q;
            res.press_y     = press_y_q;
            res.prev_x      = last_x_q;
            res.prev_y      = last_y_q;
            res.press_valid = 1'b1;
          end
          default: begin
            // Pressed, either the first press or the second of a pair.
            if (in_time) begin
              res.kind = (st == ST_CLICK_PRESS) ? pgc_pkg::KIND_DOUBLE : pgc_pkg::KIND_CLICK;
              state_d  = ST_CLICK;
            end else begin
              state_d = ST_RELEASED;
            end
          end
        endcase
      end
      pgc_pkg::OP_WHEEL: begin
        if (st == ST_DOUBLE) begin
          state_d = ST_RELEASED;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    priority if (pop_o) begin
      m_valid_d = res_valid;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RELEASED;
      press_x_q    <= '0;
      press_y_q    <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      now_q        <= '0;
      press_time_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      if (pop_o) begin
        state_q      <= state_d;
        press_x_q    <= press_x_d;
        press_y_q    <= press_y_d;
        last_x_q     <= last_x_d;
        last_y_q     <= last_y_d;
        cur_x_q      <= cur_x_d;
        cur_y_q      <= cur_y_d;
        now_q        <= now_d;
        press_time_q <= press_time_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_valid) begin
      res_q <= res;
    end
  end

  assign m_valid_o = m_valid_q;
  assign result_o  = res_q;

  a_press_valid_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_q.press_valid) |->
      (res_q.kind == pgc_pkg::KIND_DRAG_START || res_q.kind == pgc_pkg::KIND_DRAG ||
       res_q.kind == pgc_pkg::KIND_DRAG_STOP))
    else $error("press fields marked valid on a word that is not a drag");

  a_drag_stop_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && res_valid && res.kind == pgc_pkg::KIND_DRAG_STOP) |=> (state_q == ST_RELEASED))
    else $error("drag stop did not return the gesture to released");

  a_drag_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAGGING && $past(state_q) != ST_DRAGGING) |->
      ($past(state_q) == ST_PRESS || $past(state_q) == ST_CLICK_PRESS))
    else $error("drag entered from a state that is not pressed");

endmodule

// ===== sv/pointer_gesture_classifier.sv =====
// Top level of the pointer gesture classifier.
//
// This block turns a stream of pointer event words (press, move, release,
// wheel, other) into gesture words: each event is passed on unchanged, dropped,
// or replaced by a click, double click, drag start, drag step or drag stop.
// A front end takes one event word per clock while the queue is not full,
// discards empty and unknown operations, and writes the rest into a short
// queue; the gesture engine behind it pops one entry per clock while its
// output register is empty or being taken, updates the six-state gesture
// machine, the press, last and current positions and the event times, and
// loads at most one result word into its output register. The sustained rate
// is one event word per clock while the output is not stalled. An event word
// is first written into the queue; the engine then pops it and loads its
// result into the output register, and that update holds the 48-bit
// press-to-event delay compare and the squared travel compare (two 12-bit
// squares against the stored square of the shift limit). A stall on the
// output only fills the queue, so input words keep flowing until the queue
// is full. Timestamps are integer microseconds, and a zero timestamp keeps
// the previous time. Configuration registers sit at byte addresses 0 (click
// shift limit), 4 (click delay) and 8 (double click delay) and should be
// written only while no event is in flight.
module pointer_gesture_classifier #(
  parameter int unsigned QueueDepth = pgc_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Event input.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // pos_x[15:0], pos_y[31:16], button[33:32], mods[41:34], stamp_us[89:42], zero fill
  input  logic [95:0]                s_axis_tdata,
  // operation[2:0]
  input  logic [2:0]                 s_axis_tuser,
  // Gesture output.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // out_x[15:0], out_y[31:16], out_button[33:32], out_mods[41:34], press_x[57:42],
  // press_y[73:58], prev_x[89:74], prev_y[105:90], shift_x[122:106],
  // shift_y[139:123], zero fill
  output logic [143:0]               m_axis_tdata,
  // kind[3:0], press_valid[4]
  output logic [4:0]                 m_axis_tuser,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pgc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  pgc_pkg::pgc_cfg_t    cfg;
  pgc_pkg::pgc_item_t   front_item, head_item;
  pgc_pkg::pgc_result_t res;
  logic                 push, full, pop, empty;

  pgc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pgc_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .full_i    (full),
    .push_o    (push),
    .item_o    (front_item)
  );

  pgc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head_item)
  );

  pgc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .empty_i   (empty),
    .item_i    (head_item),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (res)
  );

  assign m_axis_tdata = {4'd0, res.shift_y, res.shift_x, res.prev_y, res.prev_x,
                         res.press_y, res.press_x, res.out_mods, res.out_button,
                         res.out_y, res.out_x};
  assign m_axis_tuser = {res.press_valid, res.kind};

endmodule
